[rtl/b64e_pkg.sv]
// Shared types, constants and the base64 alphabet for the line-wrapped encoder.
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] LINE_BREAK = 8'h0A;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam int unsigned LG_W      = 6;   // width of line_groups
  localparam logic [LG_W-1:0] LG_RESET = 6'd19;
  localparam int unsigned Q_DEPTH   = 2;   // group queue entries

  // Register byte addresses
  localparam logic [2:0] ADDR_LINE_GROUPS = 3'd0;

  // One finished group handed from the front to the back
  typedef struct packed {
    logic        last;   // group closes the stream
    logic        brk;    // a line break follows this group
    logic [1:0]  count;  // real bytes in the group, 1..3
    logic [23:0] bits;   // group bytes, first byte high, missing bytes zero
  } group_t;

  // Map one sextet onto the standard alphabet
  function automatic logic [7:0] sextet_char(input logic [5:0] x);
    logic [7:0] c;
    if (x < 6'd26)      c = 8'd65 + {2'b00, x};
    else if (x < 6'd52) c = 8'd71 + {2'b00, x};    // 'a' - 26
    else if (x < 6'd62) c = {2'b00, x} - 8'd4;     // '0' - 52
    else if (x == 6'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/b64e_front.sv]
// Front end: gathers input bytes into groups and decides line breaks.
`default_nettype none

module b64e_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
  input  wire logic                      s_tlast,   // last_byte
  input  wire logic [b64e_pkg::LG_W-1:0] line_groups,
  input  wire logic                      q_full,
  output logic                           push,
  output b64e_pkg::group_t               push_data
);

  logic [15:0]               held;
  logic [1:0]                phase;
  logic [b64e_pkg::LG_W-1:0] groups_on_line;

  logic                      accept;
  logic                      complete;
  logic [b64e_pkg::LG_W:0]   line_next;
  logic                      full_line;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign complete = (phase == 2'd2) || s_tlast;
  assign push     = accept && complete;

  // Group count on the line after this group; wide enough not to wrap
  assign line_next = {1'b0, groups_on_line} + 7'd1;
  assign full_line = line_next >= {1'b0, line_groups};

  // Assemble the outgoing group
  always_comb begin
    push_data.last  = s_tlast;
    push_data.brk   = full_line || s_tlast;
    push_data.count = phase + 2'd1;
    case (phase)
      2'd0:    push_data.bits = {s_tdata, 16'h0000};
      2'd1:    push_data.bits = {held[15:8], s_tdata, 8'h00};
      default: push_data.bits = {held, s_tdata};
    endcase
  end

  // Byte holding register
  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      if (phase == 2'd0) begin
        held <= {s_tdata, 8'h00};
      end else begin
        held <= {held[15:8], s_tdata};
      end
    end
  end

  // Group phase and line position
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= 2'd0;
      groups_on_line <= '0;
    end else if (accept) begin
      if (complete) begin
        phase <= 2'd0;
        if (full_line || s_tlast) begin
          groups_on_line <= '0;
        end else begin
          groups_on_line <= line_next[b64e_pkg::LG_W-1:0];
        end
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/b64e_queue.sv]
// Short queue of finished groups between front and back.
`default_nettype none

module b64e_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64e_pkg::group_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output b64e_pkg::group_t      head,
  output logic [1:0]            level
);

  b64e_pkg::group_t entries [b64e_pkg::Q_DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;

  assign full       = level == 2'(b64e_pkg::Q_DEPTH);
  assign head_valid = level != 2'd0;
  assign head       = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/b64e_back.sv]
// Back end: turns one queued group into characters, one per cycle while the output is not stalled.
`default_nettype none

module b64e_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire b64e_pkg::group_t  head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // [7:0] out_char
  output logic                   m_tlast    // last_char
);

  logic [2:0] idx;       // character position within the group, 0..4
  logic       advance;
  logic       final_ch;
  logic [7:0] ch;
  logic       ch_last;

  assign advance  = head_valid && (!m_tvalid || m_tready);
  assign final_ch = head.brk ? (idx == 3'd4) : (idx == 3'd3);
  assign pop      = advance && final_ch;

  // Character select
  always_comb begin
    ch_last = 1'b0;
    case (idx)
      3'd0: ch = b64e_pkg::sextet_char(head.bits[23:18]);
      3'd1: ch = b64e_pkg::sextet_char(head.bits[17:12]);
      3'd2: ch = (head.count >= 2'd2) ? b64e_pkg::sextet_char(head.bits[11:6])
                                      : b64e_pkg::PAD_CHAR;
      3'd3: ch = (head.count == 2'd3) ? b64e_pkg::sextet_char(head.bits[5:0])
                                      : b64e_pkg::PAD_CHAR;
      default: begin
        ch      = b64e_pkg::LINE_BREAK;
        ch_last = head.last;
      end
    endcase
  end

  // Position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (advance) begin
      idx <= final_ch ? 3'd0 : idx + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= ch;
      m_tlast <= ch_last;
    end
  end

endmodule

`default_nettype wire

[rtl/base64_line_wrapped_encoder_core.sv]
// Line-wrapped base64 encoder: top level with configuration port.
// The first character of a group passes through the group queue and the output register after
//   the byte that completes the group is accepted (queue empty, output idle); it is held until taken.
// Throughput: one byte per cycle enters while the two-entry group queue has room;
//   output is one character per cycle when not stalled: 4 per group, a line break at line end.
// Sustained rate is set by the output channel: 4 or 5 characters per 3 bytes.
// Reset (rst, synchronous) clears the queue and counters; line_groups returns to 19.
`default_nettype none

module base64_line_wrapped_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
  input  wire logic        s_tlast,    // last_byte
  // output characters
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [7:0] out_char
  output logic             m_tlast,    // last_char
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [b64e_pkg::LG_W-1:0] line_groups;
  logic                      push;
  b64e_pkg::group_t          push_data;
  logic                      q_full;
  logic                      pop;
  logic                      head_valid;
  b64e_pkg::group_t          head;
  logic [1:0]                level;

  // Register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_groups <= b64e_pkg::LG_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == b64e_pkg::ADDR_LINE_GROUPS) begin
      line_groups <= pwdata[b64e_pkg::LG_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == b64e_pkg::ADDR_LINE_GROUPS) begin
      prdata[b64e_pkg::LG_W-1:0] = line_groups;
    end
  end

  b64e_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .line_groups (line_groups),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // The stream always closes on a line break
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == b64e_pkg::LINE_BREAK)
    else $error("final character is not a line break");

  // Queue never overfills and never underflows
  assert property (@(posedge clk) disable iff (rst)
    level <= 2'(b64e_pkg::Q_DEPTH) && !(push && q_full) && !(pop && !head_valid))
    else $error("group queue overrun or underrun");

  // Input is held off exactly when the queue is full
  assert property (@(posedge clk) disable iff (rst)
    s_tready == !q_full)
    else $error("input ready disagrees with queue state");

  // Output register is empty right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
